[design/word_diff_tokenizer_assert.svh]
// assertion macros for the word diff tokenizer
`ifndef WORD_DIFF_TOKENIZER_ASSERT_SVH
`define WORD_DIFF_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define WDT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("word_diff_tokenizer check failed");

// antecedent implies consequent in the next cycle
`define WDT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("word_diff_tokenizer check failed");

`else

`define WDT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WDT_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

[design/wdt_pkg.sv]
// types, constants and byte classes for the word diff tokenizer
`timescale 1ns / 1ps

package wdt_pkg;

   localparam int unsigned MAX_LINE = 10000;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_UNDER   = 8'h5f;
   localparam logic [7:0] CHAR_HIGH    = 8'h80;

   typedef enum logic [5:0] {
      MODE_IDLE   = 6'b000001,
      MODE_START  = 6'b000010,
      MODE_WS     = 6'b000100,
      MODE_TEXT   = 6'b001000,
      MODE_SINGLE = 6'b010000,
      MODE_LONG   = 6'b100000
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BLANK  = 2'd0,
      KIND_TEXT   = 2'd1,
      KIND_SINGLE = 2'd2,
      KIND_LONG   = 2'd3
   } kind_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], CHAR_UNDER})
             || (c >= CHAR_HIGH);
   endfunction

endpackage

[design/word_diff_tokenizer.sv]
// word diff tokenizer: marks token starts, suffix bytes and token kinds in a text line
`timescale 1ns / 1ps

// Takes one byte of a text line per word and returns the same byte tagged with
// whether it opens a token, whether it is the token's one-character suffix and
// the token kind (whitespace run, text run, single byte, or whole long line).
// A line whose length, sampled with its first byte, exceeds MAX_LINE is one
// token. One word is accepted every cycle while the result side does not stall;
// each result passes through the input register, then the result register, and
// the only state carried between words is the one-hot scan mode and a newline
// flag, updated as a word moves from the input register to the result register.

module word_diff_tokenizer
   import wdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_in [7:0], line_length [23:8]
   input  logic        req_tlast,   // line_last

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // char_out [7:0]
   output logic [3:0]  rsp_tuser,   // token_start [0], in_suffix [1], token_kind [3:2]
   output logic        rsp_tlast    // line_end
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;
   logic [15:0] s1_len_ff;
   logic        s1_last_ff;

   logic        s2_valid_ff, s2_valid_in;
   logic [7:0]  s2_char_ff;
   logic        s2_start_ff, s2_start_in;
   logic        s2_suffix_ff, s2_suffix_in;
   kind_type    s2_kind_ff, s2_kind_in;
   logic        s2_last_ff;

   mode_type    mode_ff, mode_in;
   logic        newline_ff, newline_in;

   logic        s1_adv;
   logic        s2_free;
   logic        blank;
   logic        word;
   logic        is_long;
   kind_type    open_kind;
   mode_type    open_mode;
   logic        open_single;

   assign s2_free    = !s2_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;

   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s2_free);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp_tready);

   assign blank   = is_blank(s1_char_ff);
   assign word    = is_word(s1_char_ff);
   assign is_long = s1_len_ff > 16'(MAX_LINE);

   // what a byte opens when it begins a new token
   always_comb begin
      open_single = 1'b0;
      if (blank) begin
         open_kind = KIND_BLANK;
         open_mode = MODE_WS;
      end else if (word) begin
         open_kind = KIND_TEXT;
         open_mode = MODE_TEXT;
      end else begin
         open_kind   = KIND_SINGLE;
         open_mode   = MODE_SINGLE;
         open_single = 1'b1;
      end
   end

   always_comb begin
      s2_start_in  = 1'b0;
      s2_suffix_in = 1'b0;
      s2_kind_in   = open_kind;
      mode_in      = open_mode;
      newline_in   = open_single ? (s1_char_ff == CHAR_NEWLINE) : newline_ff;
      case (mode_ff)
         MODE_IDLE: begin
            s2_start_in = 1'b1;
            if (is_long) begin
               s2_kind_in = KIND_LONG;
               mode_in    = MODE_LONG;
               newline_in = newline_ff;
            end
         end
         MODE_LONG: begin
            s2_kind_in = KIND_LONG;
            mode_in    = MODE_LONG;
            newline_in = newline_ff;
         end
         MODE_WS: begin
            if (blank) begin
               mode_in = MODE_WS;
            end else begin
               s2_start_in = 1'b1;
            end
         end
         MODE_TEXT: begin
            if (word) begin
               mode_in = MODE_TEXT;
            end else if (blank) begin
               s2_suffix_in = 1'b1;
               s2_kind_in   = KIND_TEXT;
               mode_in      = MODE_START;
               newline_in   = newline_ff;
            end else begin
               s2_start_in = 1'b1;
            end
         end
         MODE_SINGLE: begin
            if (blank && !newline_ff) begin
               s2_suffix_in = 1'b1;
               s2_kind_in   = KIND_SINGLE;
               mode_in      = MODE_START;
               newline_in   = newline_ff;
            end else begin
               s2_start_in = 1'b1;
            end
         end
         default: begin
            s2_start_in = 1'b1;
         end
      endcase
      // line end returns to line start
      if (s1_last_ff) begin
         mode_in    = MODE_IDLE;
         newline_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         newline_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_adv) begin
            mode_ff    <= mode_in;
            newline_ff <= newline_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_char_ff <= req_tdata[7:0];
         s1_len_ff  <= req_tdata[23:8];
         s1_last_ff <= req_tlast;
      end
      if (s1_adv) begin
         s2_char_ff   <= s1_char_ff;
         s2_start_ff  <= s2_start_in;
         s2_suffix_ff <= s2_suffix_in;
         s2_kind_ff   <= s2_kind_in;
         s2_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_char_ff;
   assign rsp_tuser  = {s2_kind_ff, s2_suffix_ff, s2_start_ff};
   assign rsp_tlast  = s2_last_ff;

`include "word_diff_tokenizer_assert.svh"

   `WDT_ASSERT_IMP(a_suffix_not_start, clock, reset, s2_valid_ff && s2_suffix_ff, !s2_start_ff)
   `WDT_ASSERT_IMP(a_long_no_sfx, clock, reset, s2_valid_ff && s2_kind_ff == KIND_LONG, !s2_suffix_ff)
   `WDT_ASSERT_IMP(a_blank_no_sfx, clock, reset, s2_valid_ff && s2_kind_ff == KIND_BLANK, !s2_suffix_ff)
   `WDT_ASSERT_NXT(a_line_end_idle, clock, reset, s1_adv && s1_last_ff, mode_ff == MODE_IDLE && !newline_ff)

endmodule

[tb/word_diff_tokenizer_tb.sv]
// testbench for word_diff_tokenizer: byte stream in, token tags out, checked against a predictor
`timescale 1ns / 1ps

module word_diff_tokenizer_tb
   import wdt_pkg::*;
();

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_BOUNDARY,
      SCAN_BLANKS,
      SCAN_WORD,
      SCAN_LONE,
      SCAN_WHOLE
   } scan_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       start;
      logic       suffix;
      kind_type   kind;
      logic       line_end;
   } byte_tag_type;

   // directed row; the tag fields count only where known is set
   typedef struct packed {
      logic [7:0]  ch;
      logic [15:0] len;
      logic        last;
      logic        known;
      logic        start;
      logic        suffix;
      kind_type    kind;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // char_in [7:0], line_length [23:8]
   logic        req_tlast = 1'b0; // line_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // char_out [7:0]
   logic [3:0]  rsp_tuser;        // token_start [0], in_suffix [1], token_kind [3:2]
   logic        rsp_tlast;        // line_end

   scan_state_type scan_state = SCAN_IDLE;
   logic           after_newline = 1'b0;
   byte_tag_type   pending_tags[$];
   stim_row_type   rows[$];
   int unsigned    error_count = 0;
   int unsigned    req_calm = 0;
   int unsigned    rsp_wait = 0;
   int unsigned    rsp_calm = 0;
   logic           flood_on = 1'b0;
   logic           hold_off = 1'b0;

   word_diff_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic void add_row(input stim_row_type r);
      rows = {rows, r};
   endfunction

   function automatic void queue_tag(input byte_tag_type t);
      pending_tags = {pending_tags, t};
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB;
   endfunction

   function automatic logic word_char(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;   // letters fold to lower case
      if (c[7] || c == CHAR_UNDER)
         return 1'b1;
      if (c >= 8'h30 && c <= 8'h39)
         return 1'b1;
      return folded >= 8'h61 && folded <= 8'h7a;
   endfunction

   function automatic kind_type begin_token(input logic [7:0] c);
      if (blank_char(c)) begin
         scan_state = SCAN_BLANKS;
         return KIND_BLANK;
      end
      if (word_char(c)) begin
         scan_state = SCAN_WORD;
         return KIND_TEXT;
      end
      scan_state    = SCAN_LONE;
      after_newline = (c == CHAR_NEWLINE);
      return KIND_SINGLE;
   endfunction

   function automatic byte_tag_type tokenize_byte(input logic [7:0] c, input logic [15:0] len,
                                                  input logic last);
      byte_tag_type t;
      t.ch       = c;
      t.start    = 1'b0;
      t.suffix   = 1'b0;
      t.kind     = KIND_BLANK;
      t.line_end = last;
      case (scan_state)
         SCAN_IDLE: begin
            t.start = 1'b1;
            if (len > MAX_LINE) begin
               scan_state = SCAN_WHOLE;
               t.kind     = KIND_LONG;
            end else begin
               t.kind = begin_token(c);
            end
         end
         SCAN_WHOLE: begin
            t.kind = KIND_LONG;
         end
         SCAN_BLANKS: begin
            if (blank_char(c)) begin
               t.kind = KIND_BLANK;
            end else begin
               t.start = 1'b1;
               t.kind  = begin_token(c);
            end
         end
         SCAN_WORD: begin
            if (word_char(c)) begin
               t.kind = KIND_TEXT;
            end else if (blank_char(c)) begin
               t.suffix   = 1'b1;
               t.kind     = KIND_TEXT;
               scan_state = SCAN_BOUNDARY;
            end else begin
               t.start = 1'b1;
               t.kind  = begin_token(c);
            end
         end
         SCAN_LONE: begin
            // a newline never takes a suffix
            if (blank_char(c) && !after_newline) begin
               t.suffix   = 1'b1;
               t.kind     = KIND_SINGLE;
               scan_state = SCAN_BOUNDARY;
            end else begin
               t.start = 1'b1;
               t.kind  = begin_token(c);
            end
         end
         default: begin
            t.start = 1'b1;
            t.kind  = begin_token(c);
         end
      endcase
      if (last) begin
         scan_state    = SCAN_IDLE;
         after_newline = 1'b0;
      end
      return t;
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic [15:0] len, input logic last,
                            output byte_tag_type tag);
      int unsigned gap;
      gap = 0;
      if (!hold_off) begin
         if (req_calm != 0)
            req_calm--;
         else if ($urandom_range(0, 15) == 0)
            req_calm = $urandom_range(10, 40);
         else
            gap = $urandom_range(0, 19);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, c};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tag = tokenize_byte(c, len, last);
   endtask

   // result side pacing
   always @(posedge clock) begin : drain_pace
      int unsigned stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
         rsp_calm   <= 0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = 0;
         if (rsp_calm != 0)
            rsp_calm <= rsp_calm - 1;
         else if ($urandom_range(0, 15) == 0)
            rsp_calm <= $urandom_range(10, 40);
         else
            stall = $urandom_range(0, 19);
         rsp_wait   <= stall;
         rsp_tready <= (stall == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait   <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // long result stall while the sender keeps offering
   initial begin
      while (!flood_on) @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin : check_tags
      byte_tag_type got;
      byte_tag_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ch       = rsp_tdata;
         got.start    = rsp_tuser[0];
         got.suffix   = rsp_tuser[1];
         got.kind     = kind_type'(rsp_tuser[3:2]);
         got.line_end = rsp_tlast;
         if (pending_tags.size() == 0) begin
            if (error_count < 10)
               $display("unexpected word: byte %h tuser %b last %b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = pending_tags.pop_front();
            if (got !== want) begin
               if (error_count < 10)
                  $display("tag mismatch: got byte %h start %b suffix %b kind %0d end %b, %s%h %s",
                           got.ch, got.start, got.suffix, got.kind, got.line_end,
                           "expected byte ", want.ch,
                           $sformatf("start %b suffix %b kind %0d end %b",
                                     want.start, want.suffix, want.kind, want.line_end));
               error_count++;
            end
         end
      end
   end

   initial begin
      byte_tag_type tag;
      int unsigned  sent;
      int unsigned  nbytes;
      int unsigned  char_class;
      logic [15:0]  len;
      logic [7:0]   c;

      add_row('{"a",          16'd3,     1'b0, 1'b1, 1'b1, 1'b0, KIND_TEXT});
      add_row('{CHAR_SPACE,   16'd3,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{"b",          16'd3,     1'b1, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{8'hff,        16'hffff,  1'b0, 1'b1, 1'b1, 1'b0, KIND_LONG});
      add_row('{CHAR_SPACE,   16'hffff,  1'b0, 1'b1, 1'b0, 1'b0, KIND_LONG});
      add_row('{"x",          16'd0,     1'b1, 1'b1, 1'b0, 1'b0, KIND_LONG});
      add_row('{CHAR_NEWLINE, 16'd10001, 1'b1, 1'b1, 1'b1, 1'b0, KIND_LONG});
      add_row('{CHAR_TAB,     16'd10000, 1'b0, 1'b1, 1'b1, 1'b0, KIND_BLANK});
      add_row('{CHAR_SPACE,   16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{CHAR_NEWLINE, 16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{CHAR_SPACE,   16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{".",          16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{CHAR_TAB,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{8'h00,        16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{CHAR_UNDER,   16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{CHAR_HIGH,    16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{"9",          16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{CHAR_TAB,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{CHAR_SPACE,   16'd0,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{"Z",          16'd0,     1'b1, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{8'h01,        16'd0,     1'b1, 1'b1, 1'b1, 1'b0, KIND_SINGLE});
      add_row('{8'h7f,        16'd1,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{CHAR_SPACE,   16'd1,     1'b0, 1'b0, 1'b0, 1'b0, KIND_BLANK});
      add_row('{"q",          16'd1,     1'b1, 1'b0, 1'b0, 1'b0, KIND_BLANK});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_byte(rows[i].ch, rows[i].len, rows[i].last, tag);
         if (rows[i].known) begin
            tag.start  = rows[i].start;
            tag.suffix = rows[i].suffix;
            tag.kind   = rows[i].kind;
         end
         queue_tag(tag);
      end

      flood_on <= 1'b1;
      sent = 0;
      while (sent < 500) begin
         nbytes = $urandom_range(1, 24);
         case ($urandom_range(0, 9))
            0:       len = 16'($urandom_range(MAX_LINE + 1, 16'hffff));
            1:       len = 16'($urandom_range(0, 16'hffff));
            2:       len = 16'($urandom_range(0, 40));
            default: len = 16'(nbytes);
         endcase
         char_class = 0;
         for (int i = 0; i < nbytes; i++) begin
            // runs of one class so that tokens grow past their first byte
            if (i == 0 || $urandom_range(0, 2) == 0)
               char_class = $urandom_range(0, 5);
            case (char_class)
               0: c = ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB;
               1: begin
                  case ($urandom_range(0, 2))
                     0:       c = 8'($urandom_range(8'h61, 8'h7a));
                     1:       c = 8'($urandom_range(8'h41, 8'h5a));
                     default: c = 8'($urandom_range(8'h30, 8'h39));
                  endcase
               end
               2: c = ($urandom_range(0, 3) == 0) ? CHAR_UNDER
                                                  : 8'($urandom_range(8'h80, 8'hff));
               3: c = CHAR_NEWLINE;
               4: c = 8'($urandom_range(8'h21, 8'h2f));
               default: c = 8'($urandom_range(1, 8'hff));
            endcase
            send_byte(c, len, i == nbytes - 1, tag);
            queue_tag(tag);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_tags.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("word_diff_tokenizer verification clean");
      else
         $display("word_diff_tokenizer verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("word_diff_tokenizer verification failed");
      $finish;
   end

endmodule
